// ===== sv/text_console_cell_writer_unit_assert.svh =====
// Assertion macros used by the console cell writer RTL.
`ifndef TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, suppressed while reset is asserted (rstn low).
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, clk, rstn, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console cell writer.
`default_nettype none

package tcw_pkg;

  // Geometry defaults
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h07;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Cell value after reset
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/tcw_regs.sv =====
// APB configuration register: text attribute byte.
`default_nettype none

module tcw_regs
  import tcw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic      [ATTR_W-1:0]     text_color
);

  logic [ATTR_W-1:0] text_color_r, text_color_nxt;
  logic              wr_en;

  // register index is the word address
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == REG_TEXT_COLOR);

  always_comb begin
    text_color_nxt = text_color_r;
    if (wr_en) begin
      text_color_nxt = cfg_pwdata[ATTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= TEXT_COLOR_RESET;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  // read back; unused addresses read zero
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TEXT_COLOR) begin
      cfg_prdata = CFG_DATA_W'(text_color_r);
    end
  end

  assign cfg_pready = 1'b1;
  assign text_color = text_color_r;

endmodule

`default_nettype wire

// ===== sv/tcw_mem.sv =====
// Screen cell memory: one write port, one read port, registered read data.
`default_nettype none

module tcw_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH  = DEF_COLUMNS * DEF_ROWS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
// Command sequencer: cursor, put/read/clear, scroll and fill sweeps.
`default_nettype none

`include "text_console_cell_writer_unit_assert.svh"

module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ATTR_W-1:0] text_color,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_word_t              out_data,
  output logic                   mem_we,
  output logic      [ADDR_W-1:0] mem_waddr,
  output logic      [CELL_W-1:0] mem_wdata,
  output logic      [ADDR_W-1:0] mem_raddr,
  input  wire logic [CELL_W-1:0] mem_rdata
);

  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int CMP_W       = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
  localparam int SCROLL_LAST = CELLS - COLUMNS;

  // sequencer states
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic [ADDR_W-1:0] cur_lin;
  logic [CELL_W-1:0] blank;
  logic [CMP_W-1:0]  idx_ext;
  logic              accept;

  logic [COL_W:0]    col_step;
  logic              row_adv;
  logic              scroll;
  logic [ROW_W-1:0]  row_put;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [CELL_W-1:0] put_data;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cur_lin  = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign blank    = {text_color, CH_SPACE};
  assign idx_ext  = CMP_W'(in_data.cell_index);

  // put: cursor move and the single cell write, if any, that it causes
  always_comb begin
    col_step = {1'b0, col_r};
    row_adv  = 1'b0;
    put_we   = 1'b0;
    put_addr = cur_lin;
    put_data = blank;
    case (in_data.char_code)
      CH_NEWLINE: begin
        col_step = '0;
        row_adv  = 1'b1;
      end
      CH_RETURN: begin
        col_step = '0;
      end
      CH_TAB: begin
        col_step = ({1'b0, col_r} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);
      end
      CH_BACKSPACE: begin
        if (col_r != '0) begin
          col_step = {1'b0, col_r} - (COL_W+1)'(1);
          put_we   = 1'b1;
          put_addr = cur_lin - ADDR_W'(1);
        end
      end
      default: begin
        col_step = {1'b0, col_r} + (COL_W+1)'(1);
        put_we   = 1'b1;
        put_data = {text_color, in_data.char_code};
      end
    endcase
    // wrap at the last column
    if (col_step >= (COL_W+1)'(COLUMNS)) begin
      col_step = '0;
      row_adv  = 1'b1;
    end
    scroll  = row_adv && (row_r == ROW_W'(ROWS - 1));
    row_put = (row_adv && !scroll) ? row_r + ROW_W'(1) : row_r;
  end

  // sequencer and memory port control
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = blank;
    mem_raddr     = idx_ext[ADDR_W-1:0];
    case (state_r)
      ST_INIT: begin
        // post-reset sweep to the power-on blank
        mem_we    = 1'b1;
        mem_wdata = BLANK_RESET;
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          data_nxt = '0;
          case (in_data.command)
            CMD_PUT: begin
              mem_we    = put_we;
              mem_waddr = put_addr;
              mem_wdata = put_data;
              col_nxt   = col_step[COL_W-1:0];
              row_nxt   = row_put;
              ptr_nxt   = '0;
              state_nxt = scroll ? ST_SCROLL : ST_RESP;
            end
            CMD_READ: begin
              state_nxt = (idx_ext < CMP_W'(CELLS)) ? ST_READ : ST_RESP;
            end
            CMD_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              ptr_nxt   = '0;
              state_nxt = ST_FILL;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_READ: begin
        data_nxt  = mem_rdata;
        state_nxt = ST_RESP;
      end
      ST_SCROLL: begin
        // read one row ahead, write the word read last cycle one row up
        if (ptr_r != ADDR_W'(SCROLL_LAST)) begin
          mem_raddr = ptr_r + ADDR_W'(COLUMNS);
        end
        if (ptr_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_r - ADDR_W'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr_r == ADDR_W'(SCROLL_LAST)) begin
          state_nxt = ST_FILL;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        // blank from ptr to the end of the screen
        mem_we = 1'b1;
        if (ptr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt = ST_RESP;
        end else begin
          ptr_nxt = ptr_r + ADDR_W'(1);
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cursor_position = POS_W'(cur_lin);
          out_data_nxt.cell_data       = data_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `TCW_ASSERT(a_cursor_range, clk, rst_n, ((COL_W+1)'(col_r) < (COL_W+1)'(COLUMNS) && row_r <= ROW_W'(ROWS - 1)), "cursor outside screen")
  `TCW_ASSERT(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second word taken while busy")
  `TCW_ASSERT(a_write_in_range, clk, rst_n, mem_we |-> (mem_waddr <= ADDR_W'(CELLS - 1)), "cell write past end of screen")
  `TCW_ASSERT(a_scroll_to_fill, clk, rst_n, (state_r == ST_SCROLL && ptr_r == ADDR_W'(SCROLL_LAST)) |=> (state_r == ST_FILL && ptr_r == ADDR_W'(SCROLL_LAST)), "scroll did not hand over to bottom row blank")

endmodule

`default_nettype wire

// ===== sv/text_console_cell_writer_unit.sv =====
// Text console cell writer: top level.
//
//   channel  direction  handshake               word
//   in_      input      in_valid / in_ready     in_word_t (command, char, index)
//   out_     output     out_valid / out_ready   out_word_t (cursor, cell)
//   cfg_     input      APB write/read          text_color at byte address 0
//
// A put that moves past the last row starts a scroll sweep, which copies one
// cell per cycle through the single memory write port.
// After reset a clearing pass blanks all CELLS cells (2000 by default) before the
// first word is taken; configuration writes are taken meanwhile.
// A finished result waits in the output register; a new word is taken meanwhile.
`default_nettype none

module text_console_cell_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [ATTR_W-1:0] text_color;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // configuration register
  tcw_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .text_color  (text_color)
  );

  // screen memory
  tcw_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // command sequencer
  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_color (text_color),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

endmodule

`default_nettype wire
